[rtl/lmc_pkg.sv]
package lmc_pkg;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int GEAR_W     = 8;
  localparam int MODE_W     = 3;
  localparam int GEAR_NOW_W = 3;
  localparam int OVR_W      = 2;
  localparam int DRIVE_W    = 8;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 16;

  // Item kinds
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_GEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_OVR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLASH    = 2'd3;

  // Override modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAST  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_INTERVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_INTERVAL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_INVERT   = 2'd3;

  // Configuration reset values
  localparam logic [CNT_W-1:0] FLASH_DURATION_RST = 16'd100;
  localparam logic [CNT_W-1:0] SLOW_INTERVAL_RST  = 16'd500;
  localparam logic [CNT_W-1:0] FAST_INTERVAL_RST  = 16'd100;

  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
  localparam logic [DRIVE_W-1:0] DUTY_FULL  = 8'd255;

  typedef struct packed {
    logic [CNT_W-1:0] flash_duration;
    logic [CNT_W-1:0] slow_interval;
    logic [CNT_W-1:0] fast_interval;
    logic             drive_invert;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [GEAR_W-1:0] gear;
    logic [MODE_W-1:0] mode;
  } item_t;

  // PWM duty for each gear; gears 4 and up run at full duty.
  function automatic logic [DRIVE_W-1:0] gear_duty(input logic [GEAR_NOW_W-1:0] g);
    logic [DRIVE_W-1:0] d;
    case (g)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd64;
      3'd2:    d = 8'd128;
      3'd3:    d = 8'd192;
      default: d = DUTY_FULL;
    endcase
    return d;
  endfunction

endpackage

[rtl/led_indicator_mode_controller.sv]
// A word accepted into the input stage is processed by the core when it steps, which
// loads its result into the output register on the master side.
// Throughput: one word per cycle unless the master stalls (single state-update stage).
// Reset (rst, synchronous, active high) empties both stages, returns every
// configuration register to its default and clears all LED state to dark.
module led_indicator_mode_controller #(
  parameter int MAX_GEAR = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  // Slave side: one command or tick per word.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lmc_pkg::S_DATA_W-1:0]    s_tdata,  // [7:0] gear, [10:8] mode, rest zero
  input  logic [lmc_pkg::FUNC_W-1:0]      s_tuser,  // [1:0] func
  // Master side: one result word for every slave word.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lmc_pkg::M_DATA_W-1:0]    m_tdata,  // [7:0] drive, [8] led_on, rest zero
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [lmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lmc_pkg::*;

  // Configuration registers. Writes must arrive only while the block is idle, which the
  // block does not enforce; they are taken straight into the registers the core reads.
  cfg_t cfg;
  logic cfg_flash_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flash_duration <= FLASH_DURATION_RST;
      cfg.slow_interval  <= SLOW_INTERVAL_RST;
      cfg.fast_interval  <= FAST_INTERVAL_RST;
      cfg.drive_invert   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLASH_DURATION: cfg.flash_duration <= cfg_data;
        CFG_SLOW_INTERVAL:  cfg.slow_interval  <= cfg_data;
        CFG_FAST_INTERVAL:  cfg.fast_interval  <= cfg_data;
        CFG_DRIVE_INVERT:   cfg.drive_invert   <= cfg_data[0];
      endcase
    end
  end

  // Writing a zero flash length also cancels a flash that is still running.
  assign cfg_flash_clear = cfg_we && (cfg_index == CFG_FLASH_DURATION) && (cfg_data == '0);

  // Input stage. The word is held here until the output register has room;
  // the stage refills in the same cycle it drains, so a steady stream flows
  // at one word per cycle.
  logic  in_valid;
  item_t in_item;
  logic  step;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func <= s_tuser;
      in_item.gear <= s_tdata[GEAR_W-1:0];
      in_item.mode <= s_tdata[GEAR_W +: MODE_W];
    end
  end

  // The core updates the LED state for the held word and hands back the
  // drive byte and lit flag that the word produces.
  logic [DRIVE_W-1:0] res_drive;
  logic               res_lit;

  lmc_core #(
    .MAX_GEAR (MAX_GEAR)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .item            (in_item),
    .cfg             (cfg),
    .cfg_flash_clear (cfg_flash_clear),
    .res_drive       (res_drive),
    .res_lit         (res_lit)
  );

  // Output register. It loads whenever the core steps and otherwise holds
  // until the downstream side takes the word.
  logic [DRIVE_W-1:0] out_drive;
  logic               out_lit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_drive <= res_drive;
      out_lit   <= res_lit;
    end
  end

  assign m_tdata = {{(M_DATA_W - DRIVE_W - 1){1'b0}}, out_lit, out_drive};

  // A stalled result must never be overwritten by a new step.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !step)
    else $error("result register overwritten while stalled");

  // Every step leaves a valid result behind it.
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("step produced no result");

  // A held word that cannot step is kept for the next cycle.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> in_valid)
    else $error("held input word dropped");

  // An empty input stage always takes a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

endmodule

[rtl/lmc_core.sv]
module lmc_core #(
  parameter int MAX_GEAR = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  lmc_pkg::item_t               item,
  input  lmc_pkg::cfg_t                cfg,
  input  logic                         cfg_flash_clear,
  output logic [lmc_pkg::DRIVE_W-1:0]  res_drive,
  output logic                         res_lit
);
  import lmc_pkg::*;

  localparam logic [GEAR_W-1:0] MaxGear = GEAR_W'(MAX_GEAR);

  logic [GEAR_NOW_W-1:0] gear_now, gear_now_next;
  logic                  gear_mode_on, gear_mode_on_next;
  logic [OVR_W-1:0]      override_mode, override_mode_next;
  logic                  override_active, override_active_next;
  logic [CNT_W-1:0]      blink_elapsed, blink_elapsed_next;
  logic                  blink_level, blink_level_next;
  logic [CNT_W-1:0]      flash_elapsed, flash_elapsed_next;
  logic                  flash_active, flash_active_next;
  logic                  flash_level, flash_level_next;
  logic                  lit, lit_next;
  logic [DRIVE_W-1:0]    drive_level, drive_level_next;

  logic [MODE_W-1:0]     eff_mode;
  logic                  flash_ok;
  logic [CNT_W-1:0]      blink_inc;
  logic [CNT_W-1:0]      flash_inc;
  logic [CNT_W-1:0]      interval;
  logic [GEAR_W-1:0]     gear_clamped;
  logic                  gear_on_req;
  logic [DRIVE_W-1:0]    duty;

  // Mode in force: the override if one is active, else on/off from the gear.
  assign eff_mode = override_active ? {1'b0, override_mode}
                                    : (gear_mode_on ? MODE_ON : MODE_OFF);
  assign flash_ok = (cfg.flash_duration != '0) && (eff_mode != MODE_FAST);

  assign blink_inc = blink_elapsed + CNT_W'(blink_elapsed != CNT_MAX);
  assign flash_inc = flash_elapsed + CNT_W'(flash_elapsed != CNT_MAX);
  assign interval  = (eff_mode == MODE_SLOW) ? cfg.slow_interval : cfg.fast_interval;

  assign gear_clamped = (item.gear > MaxGear) ? MaxGear : item.gear;
  assign gear_on_req  = gear_clamped != '0;

  always_comb begin
    gear_now_next        = gear_now;
    gear_mode_on_next    = gear_mode_on;
    override_mode_next   = override_mode;
    override_active_next = override_active;
    blink_elapsed_next   = blink_elapsed;
    blink_level_next     = blink_level;
    flash_elapsed_next   = flash_elapsed;
    flash_active_next    = flash_active;
    flash_level_next     = flash_level;
    lit_next             = lit;
    drive_level_next     = drive_level;
    duty                 = '0;

    unique case (item.func)
      FUNC_TICK: begin
        blink_elapsed_next = blink_inc;
        flash_elapsed_next = flash_inc;
        if (flash_active && (eff_mode != MODE_FAST) && (flash_inc < cfg.flash_duration)) begin
          duty = flash_level ? DUTY_FULL : '0;
        end else begin
          if (flash_active && (eff_mode != MODE_FAST)) begin
            flash_active_next = 1'b0;
          end
          if (eff_mode == MODE_ON) begin
            duty = gear_duty(gear_now);
          end else if ((eff_mode == MODE_SLOW) || (eff_mode == MODE_FAST)) begin
            if (blink_inc >= interval) begin
              blink_level_next   = ~blink_level;
              blink_elapsed_next = '0;
            end
            duty = blink_level_next ? DUTY_FULL : '0;
          end else begin
            duty = '0;
          end
        end
        // Zero duty is dark; the polarity setting inverts the whole byte.
        lit_next         = duty != '0;
        drive_level_next = duty ^ {DRIVE_W{cfg.drive_invert}};
      end
      FUNC_SET_GEAR: begin
        gear_now_next = gear_clamped[GEAR_NOW_W-1:0];
        if (override_active || (gear_mode_on != gear_on_req)) begin
          gear_mode_on_next    = gear_on_req;
          override_active_next = 1'b0;
          blink_elapsed_next   = '0;
          blink_level_next     = 1'b0;
        end
      end
      FUNC_SET_OVR: begin
        if (item.mode == MODE_FLASH) begin
          if (flash_ok) begin
            flash_elapsed_next = '0;
            flash_level_next   = ~lit;
            flash_active_next  = 1'b1;
          end
        end else if (item.mode <= MODE_FAST) begin
          if (!override_active || ({1'b0, override_mode} != item.mode)) begin
            override_mode_next   = item.mode[OVR_W-1:0];
            override_active_next = 1'b1;
            blink_elapsed_next   = '0;
            blink_level_next     = 1'b0;
          end
          if (item.mode == MODE_FAST) begin
            flash_active_next = 1'b0;
          end
        end
      end
      FUNC_FLASH: begin
        if (flash_ok) begin
          flash_elapsed_next = '0;
          flash_level_next   = ~lit;
          flash_active_next  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_now        <= '0;
      gear_mode_on    <= 1'b0;
      override_mode   <= '0;
      override_active <= 1'b0;
      blink_elapsed   <= '0;
      blink_level     <= 1'b0;
      flash_elapsed   <= '0;
      flash_active    <= 1'b0;
      flash_level     <= 1'b0;
      lit             <= 1'b0;
      drive_level     <= '0;
    end else if (cfg_flash_clear) begin
      flash_active <= 1'b0;
    end else if (step) begin
      gear_now        <= gear_now_next;
      gear_mode_on    <= gear_mode_on_next;
      override_mode   <= override_mode_next;
      override_active <= override_active_next;
      blink_elapsed   <= blink_elapsed_next;
      blink_level     <= blink_level_next;
      flash_elapsed   <= flash_elapsed_next;
      flash_active    <= flash_active_next;
      flash_level     <= flash_level_next;
      lit             <= lit_next;
      drive_level     <= drive_level_next;
    end
  end

  assign res_drive = drive_level_next;
  assign res_lit   = lit_next;

endmodule
